>>> rtl/core/aigg_pkg.sv
// Shared types and constants for the activity idle/grace gate.
package aigg_pkg;

    localparam int TS_W      = 32;
    localparam int CFG_IDX_W = 2;

    typedef logic [TS_W-1:0] ms_t;
    typedef logic [TS_W:0]   ms_wide_t;

    typedef enum logic [1:0] {
        PH_INTERACTIVE = 2'd0,
        PH_GRACE       = 2'd1,
        PH_INHIBITED   = 2'd2
    } phase_t;

    // Register indexes on the config write port
    localparam logic [CFG_IDX_W-1:0] CFG_GATE_ENABLE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GRACE_WINDOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IDLE_THRESHOLD = 2'd2;

    // Request command codes
    localparam logic CMD_TICK     = 1'b0;
    localparam logic CMD_ACTIVITY = 1'b1;

    localparam ms_t GRACE_WINDOW_RESET   = 32'd1;
    localparam ms_t IDLE_THRESHOLD_RESET = 32'd1500;

    typedef struct packed {
        logic command;
        ms_t  now_ms;
    } item_t;

    typedef struct packed {
        phase_t phase;
        logic   inhibited;
        logic   interactive;
        ms_t    ms_in_phase;
    } result_t;

    typedef struct packed {
        logic gate_enable;
        ms_t  grace_window_ms;
        ms_t  idle_threshold_ms;
    } cfg_t;

endpackage

>>> rtl/core/aigg_in_stage.sv
// Input register stage: captures one request per cycle while it is empty or the next stage is ready.
module aigg_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           item_valid,
    output logic           item_ready,
    input  aigg_pkg::item_t item_in,
    input  logic           down_ready,
    output logic           stage_valid,
    output aigg_pkg::item_t stage_item
);
    import aigg_pkg::*;

    logic  valid_reg;
    logic  valid_next;
    item_t item_reg;
    logic  fire;
    logic  load;

    assign fire       = valid_reg && down_ready;
    assign item_ready = !valid_reg || down_ready;
    assign load       = item_valid && item_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= item_in;
        end
    end

    assign stage_valid = valid_reg;
    assign stage_item  = item_reg;

endmodule

>>> rtl/core/aigg_core.sv
// Gate state registers and the per-request phase update.
module aigg_core (
    input  logic             clk,
    input  logic             rst_n,
    input  aigg_pkg::cfg_t   cfg,
    input  logic             fire,
    input  aigg_pkg::item_t  item,
    output aigg_pkg::result_t res
);
    import aigg_pkg::*;

    phase_t   phase_reg;
    phase_t   phase_next;
    ms_t      last_reg;
    ms_t      last_next;
    ms_wide_t deadline_reg;
    ms_wide_t deadline_next;
    ms_t      entry_reg;
    ms_t      entry_next;
    ms_wide_t quiet;
    ms_t      now;

    assign now   = item.now_ms;
    // Signed quiet time; bit 32 set means time went backwards
    assign quiet = {1'b0, now} - {1'b0, last_reg};

    always_comb
    begin
        phase_next    = phase_reg;
        last_next     = last_reg;
        deadline_next = deadline_reg;
        entry_next    = entry_reg;
        if (item.command == CMD_ACTIVITY)
        begin
            if (!cfg.gate_enable)
            begin
                phase_next    = PH_GRACE;
                deadline_next = '0;
            end
            else
            begin
                last_next = now;
                if (phase_reg != PH_INTERACTIVE)
                begin
                    entry_next = now;
                end
                phase_next    = PH_INTERACTIVE;
                deadline_next = '0;
            end
        end
        else if (cfg.gate_enable)
        begin
            case (phase_reg)
                PH_INTERACTIVE:
                begin
                    if (last_reg != '0 && !quiet[TS_W] &&
                        quiet[TS_W-1:0] >= cfg.idle_threshold_ms)
                    begin
                        phase_next    = PH_GRACE;
                        deadline_next = {1'b0, now} + {1'b0, cfg.grace_window_ms};
                        entry_next    = now;
                    end
                end
                PH_GRACE:
                begin
                    // zero deadline: grace entered while disabled, no timeout
                    if (deadline_reg != '0 && {1'b0, now} >= deadline_reg)
                    begin
                        phase_next = PH_INHIBITED;
                        entry_next = now;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_comb
    begin
        res.phase       = phase_next;
        res.inhibited   = cfg.gate_enable && (phase_next == PH_INHIBITED);
        res.interactive = cfg.gate_enable && (phase_next == PH_INTERACTIVE);
        res.ms_in_phase = '0;
        if (entry_next != '0 && now >= entry_next)
        begin
            res.ms_in_phase = now - entry_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_INTERACTIVE;
            last_reg     <= '0;
            deadline_reg <= '0;
            entry_reg    <= '0;
        end
        else if (fire)
        begin
            phase_reg    <= phase_next;
            last_reg     <= last_next;
            deadline_reg <= deadline_next;
            entry_reg    <= entry_next;
        end
    end

endmodule

>>> rtl/core/aigg_out_stage.sv
// Result register stage: holds one result until the receiver takes it.
module aigg_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  aigg_pkg::result_t res_in,
    output logic              up_ready,
    output logic              result_valid,
    input  logic              result_ready,
    output aigg_pkg::result_t res_out
);
    import aigg_pkg::*;

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    assign up_ready = !valid_reg || result_ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (result_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign result_valid = valid_reg;
    assign res_out      = res_reg;

endmodule

>>> rtl/core/activity_idle_grace_gate_top.sv
// Top level of the activity idle/grace gate.
//
// Usage:
//   Request channel (item_valid/item_ready): command (0 tick, 1 activity)
//   and now_ms timestamp. Result channel (result_valid/result_ready): phase,
//   inhibited, interactive and ms_in_phase, exactly one result per request.
//   Config port: cfg_we with cfg_index/cfg_data writes a register (0 gate_enable,
//   1 grace_window_ms, 2 idle_threshold_ms); index 3
//   is ignored. Write config only while no request is in flight.
// Pipeline and throughput:
//   A request lands in the input register, then the phase update runs in one
//   combinational pass of compares, adds and subtracts into the result
//   register, from which the receiver takes it. One request per cycle
//   sustained while result_ready stays high.
// Stall:
//   When result_ready is low the result register holds; one more request
//   waits in the input register, then item_ready drops. No request is lost.
// Reset:
//   Phase interactive, all timestamps zero (never), no grace deadline,
//   gate enabled, grace window 1 ms, idle threshold 1500 ms.
module activity_idle_grace_gate_top (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  logic                          command,
    input  logic [31:0]                   now_ms,
    output logic                          result_valid,
    input  logic                          result_ready,
    output logic [1:0]                    phase,
    output logic                          inhibited,
    output logic                          interactive,
    output logic [31:0]                   ms_in_phase,
    input  logic                          cfg_we,
    input  logic [aigg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]                   cfg_data
);
    import aigg_pkg::*;

    cfg_t    cfg_reg;
    cfg_t    cfg_next;
    item_t   item_in;
    item_t   stage_item;
    logic    stage_valid;
    logic    out_up_ready;
    logic    fire;
    result_t core_res;
    result_t out_res;

    // Config registers; a zero grace window is stored as one
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                CFG_GATE_ENABLE:    cfg_next.gate_enable = cfg_data[0];
                CFG_GRACE_WINDOW:   cfg_next.grace_window_ms =
                                        (cfg_data == '0) ? GRACE_WINDOW_RESET : cfg_data;
                CFG_IDLE_THRESHOLD: cfg_next.idle_threshold_ms = cfg_data;
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.gate_enable       <= 1'b1;
            cfg_reg.grace_window_ms   <= GRACE_WINDOW_RESET;
            cfg_reg.idle_threshold_ms <= IDLE_THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign item_in.command = command;
    assign item_in.now_ms  = now_ms;

    // Request moves from input register into the result register
    assign fire = stage_valid && out_up_ready;

    aigg_in_stage u_in_stage (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item_in     (item_in),
        .down_ready  (out_up_ready),
        .stage_valid (stage_valid),
        .stage_item  (stage_item)
    );

    aigg_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg_reg),
        .fire  (fire),
        .item  (stage_item),
        .res   (core_res)
    );

    aigg_out_stage u_out_stage (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (fire),
        .res_in       (core_res),
        .up_ready     (out_up_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .res_out      (out_res)
    );

    assign phase       = out_res.phase;
    assign inhibited   = out_res.inhibited;
    assign interactive = out_res.interactive;
    assign ms_in_phase = out_res.ms_in_phase;

endmodule
